@@ hdl/trace_event_statistics_assert.svh @@
// Assertion macros for the trace statistics block.
`ifndef TRACE_EVENT_STATISTICS_ASSERT_SVH
`define TRACE_EVENT_STATISTICS_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TES_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trace statistics check failed");

// Check cons in the cycle after ante.
`define TES_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trace statistics check failed");

`endif

@@ hdl/tes_pkg.sv @@
`timescale 1ns / 1ps

package tes_pkg;

  typedef logic [3:0]  ev_idx_t;
  typedef logic [15:0][31:0] ev_row_t;
  typedef logic [3:0][63:0]  wt_row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_AGG,
    ST_DONE
  } state_t;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_AGG    = 2'd2;

  localparam logic [2:0] OP_DMISS   = 3'd0;
  localparam logic [2:0] OP_IMISS   = 3'd1;
  localparam logic [2:0] OP_EVICT   = 3'd2;
  localparam logic [2:0] OP_WFI     = 3'd3;
  localparam logic [2:0] OP_WAITFOR = 3'd4;
  localparam logic [2:0] OP_WAIT    = 3'd5;
  localparam logic [2:0] OP_ATOMIC  = 3'd6;
  localparam logic [2:0] OP_BAD     = 3'd7;

  localparam logic [1:0] CLS_LD_NX = 2'd0;
  localparam logic [1:0] CLS_ST_NX = 2'd1;
  localparam logic [1:0] CLS_LD_EX = 2'd2;
  localparam logic [1:0] CLS_ST_EX = 2'd3;

  localparam ev_idx_t EV_RECORDS = 4'd0;
  localparam ev_idx_t EV_DMISS   = 4'd1;
  localparam ev_idx_t EV_IMISS   = 4'd2;
  localparam ev_idx_t EV_EVICT   = 4'd3;
  localparam ev_idx_t EV_WFI     = 4'd4;
  localparam ev_idx_t EV_WAITFOR = 4'd5;
  localparam ev_idx_t EV_WAIT    = 4'd6;
  localparam ev_idx_t EV_ATOMIC  = 4'd7;
  localparam ev_idx_t EV_LD_EX   = 4'd8;
  localparam ev_idx_t EV_LD_NX   = 4'd9;
  localparam ev_idx_t EV_ST_EX   = 4'd10;
  localparam ev_idx_t EV_ST_NX   = 4'd11;
  localparam ev_idx_t EV_LOAD    = 4'd12;
  localparam ev_idx_t EV_STORE   = 4'd13;
  localparam ev_idx_t EV_EXCL    = 4'd14;
  localparam ev_idx_t EV_NONEXCL = 4'd15;

  localparam logic [4:0] SEL_WAIT_BASE = 5'd16;
  localparam logic [4:0] SEL_LIMIT     = 5'd20;

  localparam logic [6:0] SOURCES_IN_USE_RST = 7'd64;

  function automatic logic [63:0] counter_pick(ev_row_t ev, wt_row_t wt, logic [4:0] sel);
    logic [63:0] v;
    v = '0;
    if (sel < SEL_WAIT_BASE) begin
      v = {32'b0, ev[sel[3:0]]};
    end else if (sel < SEL_LIMIT) begin
      v = wt[sel[1:0]];
    end
    return v;
  endfunction

endpackage

@@ hdl/tes_ram.sv @@
`timescale 1ns / 1ps

module tes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/tes_update.sv @@
`timescale 1ns / 1ps

module tes_update (
  input  logic [63:0]      word,
  input  tes_pkg::ev_row_t ev_row,
  input  tes_pkg::wt_row_t wt_row,
  output tes_pkg::ev_row_t ev_new,
  output tes_pkg::wt_row_t wt_new,
  output logic             bad
);

  logic [63:0] t;
  logic [2:0]  op;
  logic [1:0]  cls;
  logic [15:0] inc;
  logic [31:0] c;
  logic [7:0]  c8;
  logic [5:0]  c6;
  logic [3:0]  c4;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      t[8*i +: 8] = word[8*(7-i) +: 8];
    end
  end

  assign op  = t[2:0];
  assign cls = t[4:3];
  assign c   = t[39:8];
  assign c8  = (c[7:0] == 8'd0) ? 8'd1 : c[7:0];
  assign c6  = (c8[5:0] == 6'd0) ? 6'd1 : c8[5:0];
  assign c4  = (c6[3:0] == 4'd0) ? 4'd1 : c6[3:0];
  assign bad = (op == tes_pkg::OP_BAD);

  always_comb begin
    inc = '0;
    inc[tes_pkg::EV_RECORDS] = 1'b1;
    case (op)
      tes_pkg::OP_DMISS, tes_pkg::OP_IMISS: begin
        inc[(op == tes_pkg::OP_DMISS) ? tes_pkg::EV_DMISS : tes_pkg::EV_IMISS] = 1'b1;
        case (cls)
          tes_pkg::CLS_LD_NX: inc[tes_pkg::EV_LD_NX] = 1'b1;
          tes_pkg::CLS_ST_NX: inc[tes_pkg::EV_ST_NX] = 1'b1;
          tes_pkg::CLS_LD_EX: inc[tes_pkg::EV_LD_EX] = 1'b1;
          default:            inc[tes_pkg::EV_ST_EX] = 1'b1;
        endcase
        inc[cls[0] ? tes_pkg::EV_STORE : tes_pkg::EV_LOAD]    = 1'b1;
        inc[cls[1] ? tes_pkg::EV_EXCL  : tes_pkg::EV_NONEXCL] = 1'b1;
      end
      tes_pkg::OP_EVICT:   inc[tes_pkg::EV_EVICT]   = 1'b1;
      tes_pkg::OP_WFI:     inc[tes_pkg::EV_WFI]     = 1'b1;
      tes_pkg::OP_WAITFOR: inc[tes_pkg::EV_WAITFOR] = 1'b1;
      tes_pkg::OP_WAIT:    inc[tes_pkg::EV_WAIT]    = 1'b1;
      tes_pkg::OP_ATOMIC:  inc[tes_pkg::EV_ATOMIC]  = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      ev_new[k] = ev_row[k] + {31'b0, inc[k]};
    end
    wt_new = wt_row;
    if (op == tes_pkg::OP_WAIT) begin
      wt_new[0] = wt_row[0] + {32'b0, c};
      wt_new[1] = wt_row[1] + {56'b0, c8};
      wt_new[2] = wt_row[2] + {58'b0, c6};
      wt_new[3] = wt_row[3] + {60'b0, c4};
    end
  end

endmodule

@@ hdl/trace_event_statistics.sv @@
`timescale 1ns / 1ps
// Record and read requests: the counter RAMs are read on acceptance, and the EXEC
// state does the read-modify-write of one source row and loads the output; no new
// request is taken before that. Aggregate requests walk one source row per cycle
// over min(sources_in_use, SOURCES) rows. Requests are taken while a result waits.
// Reset (rst, synchronous) clears the per-source row valid bits, so every counter
// reads zero, and sets sources_in_use to 64.

module trace_event_statistics #(
  parameter int SOURCES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // source[5:0], trace_word[69:6], counter_sel[74:70]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // read_value[63:0]
  output logic [0:0]  m_tuser,   // bad_opcode[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int AW = SOURCES > 1 ? $clog2(SOURCES) : 1;
  localparam int NW = $clog2(SOURCES + 1);
  localparam logic [8:0] SRC_CNT = 9'(SOURCES);

  tes_pkg::state_t state, state_next;

  logic [1:0]   cmd_q;
  logic [AW-1:0] src_q;
  logic [63:0]  word_q;
  logic [4:0]   sel_q;
  logic         in_range_q;
  logic [6:0]   sources_in_use;
  logic [NW-1:0] n;
  logic         pend;
  logic [63:0]  acc;
  logic [63:0]  res_val;
  logic         res_bad;
  logic [SOURCES-1:0] row_valid;
  logic [AW-1:0] rd_addr_q;

  logic [1:0]   in_cmd;
  logic [5:0]   in_source;
  logic [63:0]  in_word;
  logic [4:0]   in_sel;
  logic         in_range;
  logic         accept;
  logic         out_free;
  logic [8:0]   lim;
  logic         n_lt;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic          load_out;
  logic [63:0]   exec_val;
  logic          exec_bad;

  tes_pkg::ev_row_t ev_rdata, ev_row, ev_new;
  tes_pkg::wt_row_t wt_rdata, wt_row, wt_new;
  logic             upd_bad;
  logic [63:0]      pick;

  assign in_cmd    = s_tuser;
  assign in_source = s_tdata[5:0];
  assign in_word   = s_tdata[69:6];
  assign in_sel    = s_tdata[74:70];
  assign in_range  = {3'b0, in_source} < SRC_CNT;

  assign s_tready  = (state == tes_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign lim  = ({2'b0, sources_in_use} > SRC_CNT) ? SRC_CNT : {2'b0, sources_in_use};
  assign n_lt = 9'(n) < lim;

  assign ev_row = row_valid[rd_addr_q] ? ev_rdata : '0;
  assign wt_row = row_valid[rd_addr_q] ? wt_rdata : '0;
  assign pick   = tes_pkg::counter_pick(ev_row, wt_row, sel_q);

  tes_ram #(
    .WIDTH ($bits(tes_pkg::ev_row_t)),
    .DEPTH (SOURCES)
  ) u_ev_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (src_q),
    .wdata (ev_new),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ev_rdata)
  );

  tes_ram #(
    .WIDTH ($bits(tes_pkg::wt_row_t)),
    .DEPTH (SOURCES)
  ) u_wt_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (src_q),
    .wdata (wt_new),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (wt_rdata)
  );

  tes_update u_update (
    .word   (word_q),
    .ev_row (ev_row),
    .wt_row (wt_row),
    .ev_new (ev_new),
    .wt_new (wt_new),
    .bad    (upd_bad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = AW'(in_source);
    mem_we     = 1'b0;
    load_out   = 1'b0;
    exec_val   = '0;
    exec_bad   = 1'b0;
    case (state)
      tes_pkg::ST_IDLE: begin
        rd_en = accept;
        if (accept) begin
          state_next = (in_cmd == tes_pkg::CMD_AGG) ? tes_pkg::ST_AGG : tes_pkg::ST_EXEC;
        end
      end
      tes_pkg::ST_EXEC: begin
        if (in_range_q && cmd_q == tes_pkg::CMD_RECORD) begin
          mem_we   = 1'b1;
          exec_val = {32'b0, ev_new[tes_pkg::EV_RECORDS]};
          exec_bad = upd_bad;
        end else if (in_range_q && cmd_q == tes_pkg::CMD_READ) begin
          exec_val = pick;
        end
        load_out   = out_free;
        state_next = out_free ? tes_pkg::ST_IDLE : tes_pkg::ST_DONE;
      end
      tes_pkg::ST_AGG: begin
        rd_en   = n_lt;
        rd_addr = n[AW-1:0];
        if (!pend && !n_lt) begin
          state_next = tes_pkg::ST_DONE;
        end
      end
      tes_pkg::ST_DONE: begin
        load_out = out_free;
        if (out_free) begin
          state_next = tes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid      <= '0;
      sources_in_use <= tes_pkg::SOURCES_IN_USE_RST;
      m_tvalid       <= 1'b0;
      pend           <= 1'b0;
      n              <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sources_in_use <= cfg_data;
      end
      if (mem_we) begin
        row_valid[src_q] <= 1'b1;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        n    <= '0;
        pend <= 1'b0;
      end else if (state == tes_pkg::ST_AGG) begin
        if (rd_en) begin
          n <= n + NW'(1);
        end
        pend <= rd_en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (accept) begin
      cmd_q      <= in_cmd;
      src_q      <= AW'(in_source);
      word_q     <= in_word;
      sel_q      <= in_sel;
      in_range_q <= in_range;
      acc        <= '0;
    end else if (state == tes_pkg::ST_AGG && pend) begin
      if (sel_q >= tes_pkg::SEL_WAIT_BASE) begin
        acc <= (pick > acc) ? pick : acc;
      end else begin
        acc <= acc + pick;
      end
    end
    if (state == tes_pkg::ST_EXEC) begin
      res_val <= exec_val;
      res_bad <= exec_bad;
    end else if (state == tes_pkg::ST_AGG) begin
      res_val <= acc;
      res_bad <= 1'b0;
    end
    if (load_out) begin
      m_tdata    <= (state == tes_pkg::ST_EXEC) ? exec_val : res_val;
      m_tuser[0] <= (state == tes_pkg::ST_EXEC) ? exec_bad : res_bad;
    end
  end

endmodule

@@ hdl/tes_checker.sv @@
`timescale 1ns / 1ps
`include "trace_event_statistics_assert.svh"

module tes_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser
);

  `TES_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `TES_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `TES_ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready)
  `TES_ASSERT_NOW(a_bad_is_count, clk, rst, m_tvalid && m_tuser[0], m_tdata[63:32] == 32'd0)

endmodule

bind trace_event_statistics tes_checker u_tes_checker (.*);
